// File: design/cfp_pkg.sv
// Shared types and constants for the colon field message parser.
// No dependencies; used by cfp_cfg, cfp_parse and the top level.
`default_nettype none

package cfp_pkg;

    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 5;

    localparam logic [7:0] COLON_CHAR         = 8'd58;
    localparam logic [7:0] DIGIT_ZERO         = 8'd48;
    localparam logic [7:0] DIGIT_NINE         = 8'd57;
    localparam logic [4:0] PAYLOAD_OPEN_COUNT = 5'd7;
    localparam logic [3:0] LENGTH_FIELD       = 4'd5;
    localparam logic [3:0] PAYLOAD_FIELD      = 4'd6;
    localparam logic [3:0] HOPS_FIELD         = 4'd7;

    // register indexes, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_SENDER      = 3'd0,
        REG_RECEIVER    = 3'd1,
        REG_REQUEST     = 3'd2,
        REG_TOPIC       = 3'd3,
        REG_CHAPTER     = 3'd4,
        REG_LENGTH_TEXT = 3'd5,
        REG_HOPS        = 3'd6,
        REG_CHECK       = 3'd7
    } reg_idx_t;

    typedef logic [NUM_REGS-1:0][7:0] cfg_regs_t;

    localparam cfg_regs_t REG_RESET = {8'd8, 8'd4, 8'd4, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16};

    typedef struct packed {
        logic       message_done;
        logic       payload_start;
        logic [7:0] payload_len;
        logic [7:0] byte_out;
        logic [7:0] position;
        logic [3:0] field_index;
        logic       end_strobe;
        logic       store_strobe;
        logic       link_out;
    } result_t;

endpackage

`default_nettype wire

// File: design/cfp_cfg.sv
// APB-style configuration registers: per-field highest write positions.
// Depends on cfp_pkg.
`default_nettype none

module cfp_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output cfp_pkg::cfg_regs_t               cfg_regs
);

    cfp_pkg::cfg_regs_t regs_reg;
    logic [2:0]         idx;
    logic               wr_en;

    assign idx    = paddr[cfp_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= cfp_pkg::REG_RESET;
        end else if (wr_en) begin
            regs_reg[idx] <= pwdata[7:0];
        end
    end

    assign prdata   = {24'd0, regs_reg[idx]};
    assign cfg_regs = regs_reg;

endmodule

`default_nettype wire

// File: design/cfp_parse.sv
// Per-port parse state and the combinational step that turns one byte into a result.
// Depends on cfp_pkg.
`default_nettype none

module cfp_parse #(
    parameter int PAYLOAD_MAX = 255,
    parameter int FIELD_COUNT = 9,
    parameter int PORTS       = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic [7:0]         ch,
    input  wire logic               link,
    input  wire cfp_pkg::cfg_regs_t cfg_regs,
    output logic                    port_ok,
    output cfp_pkg::result_t        res
);

    logic [3:0] fc_reg  [PORTS];
    logic [7:0] cp_reg  [PORTS];
    logic       inp_reg [PORTS];
    logic [7:0] acc_reg [PORTS];

    logic [3:0]  fc;
    logic [7:0]  cp;
    logic        inp;
    logic [7:0]  acc;
    logic [4:0]  fc_next;
    logic [7:0]  cp_next;
    logic        inp_next;
    logic [7:0]  acc_next;
    logic [3:0]  f;
    logic [11:0] dec;

    function automatic logic [7:0] limit_of(input logic [3:0] fld,
                                            input cfp_pkg::cfg_regs_t r);
        logic [7:0] lim;
        if (fld <= cfp_pkg::LENGTH_FIELD) lim = r[fld[2:0]];
        else if (fld == cfp_pkg::PAYLOAD_FIELD) lim = 8'd0;
        else if (fld == cfp_pkg::HOPS_FIELD) lim = r[cfp_pkg::REG_HOPS];
        else lim = r[cfp_pkg::REG_CHECK];
        return lim;
    endfunction

    assign port_ok = (32'(link) < PORTS);

    always_comb begin
        fc  = fc_reg[link];
        cp  = cp_reg[link];
        inp = inp_reg[link];
        acc = (32'(acc_reg[link]) > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : acc_reg[link];

        fc_next  = {1'b0, fc};
        cp_next  = cp;
        inp_next = inp;
        acc_next = acc;
        f        = fc - 4'd1;
        dec      = 12'({4'd0, acc} * 12'd10) + 12'({4'd0, ch - cfp_pkg::DIGIT_ZERO});
        res      = '0;
        res.link_out = link;

        if (inp) begin
            res.field_index = cfp_pkg::PAYLOAD_FIELD;
            res.position    = cp;
            if (cp < acc) begin
                res.store_strobe = 1'b1;
                res.byte_out     = ch;
                cp_next          = cp + 8'd1;
            end else begin
                res.end_strobe = 1'b1;
                inp_next       = 1'b0;
                fc_next        = {1'b0, fc} + 5'd1;
                cp_next        = 8'd0;
            end
        end else if (ch == cfp_pkg::COLON_CHAR) begin
            if (fc != 4'd0) begin
                res.end_strobe  = 1'b1;
                res.field_index = f;
                res.position    = cp;
            end
            fc_next = {1'b0, fc} + 5'd1;
            cp_next = 8'd0;
            if (fc_next == 5'({1'b0, cfp_pkg::LENGTH_FIELD}) + 5'd1) acc_next = 8'd0;
            if (fc_next == cfp_pkg::PAYLOAD_OPEN_COUNT) res.payload_start = 1'b1;
        end else if (fc != 4'd0) begin
            if (cp <= limit_of(f, cfg_regs)) begin
                res.store_strobe = 1'b1;
                res.field_index  = f;
                res.position     = cp;
                res.byte_out     = ch;
                cp_next          = cp + 8'd1;
                if (f == cfp_pkg::LENGTH_FIELD && ch >= cfp_pkg::DIGIT_ZERO
                    && ch <= cfp_pkg::DIGIT_NINE) begin
                    // decimal shift-in, clamped
                    acc_next = (32'(dec) > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : dec[7:0];
                end
            end else begin
                // overlong entry: restart the field, drop the byte
                cp_next = 8'd0;
                if (f == cfp_pkg::LENGTH_FIELD) acc_next = 8'd0;
            end
        end

        if (32'(fc_next) > FIELD_COUNT) begin
            fc_next          = 5'd0;
            res.message_done = 1'b1;
        end
        if (res.payload_start) inp_next = 1'b1;
        res.payload_len = acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORTS; i++) begin
                fc_reg[i]  <= 4'd0;
                cp_reg[i]  <= 8'd0;
                inp_reg[i] <= 1'b0;
                acc_reg[i] <= 8'd0;
            end
        end else if (step_en && port_ok) begin
            fc_reg[link]  <= fc_next[3:0];
            cp_reg[link]  <= cp_next;
            inp_reg[link] <= inp_next;
            acc_reg[link] <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: design/colon_field_message_parser.sv
// Top level of the colon field message parser: input register, parse step, result register.
// Depends on cfp_pkg, cfp_cfg and cfp_parse.
`default_nettype none

// Byte-stream parser for colon-separated messages on up to two receive ports,
// each with its own parse state. Send one byte per word on s_tdata with its
// port number on s_tuser; every byte from a present port yields exactly one
// result word (bytes tagged with a port at or above PORTS are dropped). The
// block takes one byte per clock while the result side is not stalled: a
// byte is captured in an input register, then one combinational step reads
// that port's state and loads the result register; throughput is one word
// per cycle, limited only by m_tready. Bytes before the first colon are ignored;
// each text field stores up to its configured highest position, and one byte
// past it restarts the field and is dropped. Field 5 holds the payload length
// in decimal (saturating at PAYLOAD_MAX); the colon opening field 6 raises
// payload_start, then exactly that many raw bytes are stored and the next byte
// writes the payload terminator. The colon after the last field raises
// message_done. Limits live at APB byte addresses 0x00..0x1C and must be
// written only while the block is idle. No clearing pass is needed after reset.
module colon_field_message_parser #(
    parameter int PAYLOAD_MAX = 255,
    parameter int FIELD_COUNT = 9,
    parameter int PORTS       = 2
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input byte stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    input  wire logic                        s_tuser,   // [0] link
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] store_strobe, [1] end_strobe, [5:2] field_index, [13:6] position,
    // [21:14] byte_out, [29:22] payload_len, [30] payload_start, [31] message_done
    output logic [31:0]                      m_tdata,
    output logic                             m_tuser,   // [0] link_out
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    cfp_pkg::cfg_regs_t cfg_regs;
    cfp_pkg::result_t   step_res;
    cfp_pkg::result_t   out_res_reg;
    logic               port_ok;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_link_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               consume;

    // result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    cfp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg_regs (cfg_regs)
    );

    cfp_parse #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .FIELD_COUNT (FIELD_COUNT),
        .PORTS       (PORTS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (consume),
        .ch       (in_byte_reg),
        .link     (in_link_reg),
        .cfg_regs (cfg_regs),
        .port_ok  (port_ok),
        .res      (step_res)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) out_valid_reg <= in_valid_reg && port_ok;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_link_reg <= s_tuser;
        end
        if (consume) out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.link_out;
    assign m_tdata  = out_res_reg[31+1:1];

`ifndef SYNTHESIS
    // a result never both stores and terminates
    a_strobe_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res_reg.store_strobe && out_res_reg.end_strobe))
        else $error("store and end strobe together");

    // finishing a message always writes the last field's terminator
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.message_done) |-> out_res_reg.end_strobe)
        else $error("message_done without terminator");

    // payload mode opens only on the colon that closes the length field
    a_pstart_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.payload_start) |->
        (out_res_reg.end_strobe && out_res_reg.field_index == cfp_pkg::LENGTH_FIELD))
        else $error("payload_start off the length field");

    // raw payload stores stay below the decoded length
    a_payload_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.store_strobe
         && out_res_reg.field_index == cfp_pkg::PAYLOAD_FIELD) |->
        (out_res_reg.position < out_res_reg.payload_len))
        else $error("payload store past length");
`endif

endmodule

`default_nettype wire

// File: dv/tb_colon_field_message_parser.sv
// Self-checking testbench for colon_field_message_parser: byte stream in, one result word out.
// Depends on cfp_pkg (register indexes, character codes, result layout) and the RTL top level.
module tb_colon_field_message_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // must match the block's default parameters
    localparam int PAYLOAD_MAX = 255;
    localparam int FIELD_COUNT = 9;
    localparam int PORTS       = 2;
    localparam int CYCLE_LIMIT = 400_000;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;
    wire logic   m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [cfp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    wire logic [31:0] prdata;
    wire logic   pready;

    colon_field_message_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Shadow of the parser: per-port parse state and the field limits
    // ---------------------------------------------------------------
    cfp_pkg::cfg_regs_t field_limit = cfp_pkg::REG_RESET;
    logic [3:0]  port_field_cnt [PORTS] = '{default: '0};
    logic [7:0]  port_char_pos  [PORTS] = '{default: '0};
    logic        port_in_payload[PORTS] = '{default: '0};
    logic [7:0]  port_len_acc   [PORTS] = '{default: '0};

    cfp_pkg::result_t predicted_writes[$];

    // run control and bookkeeping
    int send_idle_pct   = 0;
    int rx_stall_pct    = 0;
    int hold_len        = 0;
    int hold_reqs       = 0;
    int hold_taken      = 0;
    int hold_left       = 0;
    int bytes_sent      = 0;
    int words_checked   = 0;
    int messages_seen   = 0;
    int limit_sets      = 0;
    int errors          = 0;
    int cycle_count     = 0;

    // Advance one port by one byte and queue the word the block must produce.
    task automatic parse_byte(logic [7:0] ch, logic p);
        cfp_pkg::result_t r;
        int fc, cp, f, lim, v;
        if (p >= PORTS) return;        // absent port: dropped, no word
        r = '0;
        r.link_out = p;
        fc = port_field_cnt[p];
        cp = port_char_pos[p];
        if (port_in_payload[p]) begin
            // raw payload: count bytes against the decoded length
            r.field_index = cfp_pkg::PAYLOAD_FIELD;
            r.position    = 8'(cp);
            if (cp < port_len_acc[p]) begin
                r.store_strobe = 1'b1;
                r.byte_out     = ch;
                cp = (cp + 1) & 8'hFF;
            end else begin
                // byte after the payload: terminator, opens the hop field
                r.end_strobe = 1'b1;
                port_in_payload[p] = 1'b0;
                fc++;
                cp = 0;
            end
        end else if (ch == cfp_pkg::COLON_CHAR) begin
            if (fc > 0) begin
                r.end_strobe  = 1'b1;
                r.field_index = 4'(fc - 1);
                r.position    = 8'(cp);
            end
            fc++;
            cp = 0;
            if (fc == cfp_pkg::LENGTH_FIELD + 1) port_len_acc[p] = '0;
            if (fc == cfp_pkg::PAYLOAD_OPEN_COUNT) r.payload_start = 1'b1;
        end else if (fc > 0) begin
            f = fc - 1;
            if (f <= cfp_pkg::LENGTH_FIELD)       lim = field_limit[f];
            else if (f == cfp_pkg::PAYLOAD_FIELD) lim = 0;
            else if (f == cfp_pkg::HOPS_FIELD)    lim = field_limit[cfp_pkg::REG_HOPS];
            else                                  lim = field_limit[cfp_pkg::REG_CHECK];
            if (cp <= lim) begin
                r.store_strobe = 1'b1;
                r.field_index  = 4'(f);
                r.position     = 8'(cp);
                r.byte_out     = ch;
                if (f == cfp_pkg::LENGTH_FIELD && ch >= cfp_pkg::DIGIT_ZERO
                    && ch <= cfp_pkg::DIGIT_NINE) begin
                    v = port_len_acc[p] * 10 + (ch - cfp_pkg::DIGIT_ZERO);
                    if (v > PAYLOAD_MAX) v = PAYLOAD_MAX;
                    port_len_acc[p] = 8'(v);
                end
                cp = (cp + 1) & 8'hFF;
            end else begin
                // one byte past the limit: field restarts, byte dropped
                cp = 0;
                if (f == cfp_pkg::LENGTH_FIELD) port_len_acc[p] = '0;
            end
        end
        if (fc > FIELD_COUNT) begin
            fc = 0;
            r.message_done = 1'b1;
        end
        if (r.payload_start) port_in_payload[p] = 1'b1;
        port_field_cnt[p] = 4'(fc);
        port_char_pos[p]  = 8'(cp);
        r.payload_len     = port_len_acc[p];
        predicted_writes.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Result side: word checking, random stalls, long hold-off
    // ---------------------------------------------------------------
    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cfp_pkg::result_t got, want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = cfp_pkg::result_t'({m_tdata, m_tuser});
            if (predicted_writes.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
            end else begin
                want = predicted_writes.pop_front();
                compare_field("link_out",      want.link_out,      got.link_out);
                compare_field("store_strobe",  want.store_strobe,  got.store_strobe);
                compare_field("end_strobe",    want.end_strobe,    got.end_strobe);
                compare_field("field_index",   want.field_index,   got.field_index);
                compare_field("position",      want.position,      got.position);
                compare_field("byte_out",      want.byte_out,      got.byte_out);
                compare_field("payload_len",   want.payload_len,   got.payload_len);
                compare_field("payload_start", want.payload_start, got.payload_start);
                compare_field("message_done",  want.message_done,  got.message_done);
                if (want.message_done) messages_seen++;
            end
            words_checked++;
        end
    end

    // receiver: a requested hold-off stretch wins over the random stall
    always @(posedge aclk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken <= hold_reqs;
            hold_left  <= hold_len;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, predicted_writes.size());
            $display("tb_colon_field_message_parser: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Offer one byte; returns in the step of the edge that accepted it.
    task automatic send_word(logic [7:0] ch, logic p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= p;
        do @(posedge aclk); while (s_tready !== 1'b1);
        parse_byte(ch, p);
        bytes_sent++;
    endtask

    // Interleave two per-port byte streams at random.
    task automatic send_pair(byte_q_t q0, byte_q_t q1);
        int pick;
        while (q0.size() + q1.size() > 0) begin
            pick = (q0.size() == 0) ? 1 : (q1.size() == 0) ? 0 : $urandom_range(1);
            if (pick == 0) send_word(q0.pop_front(), 1'b0);
            else           send_word(q1.pop_front(), 1'b1);
        end
    endtask

    // Sender stops and waits for every outstanding word, plus pipeline slack.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (predicted_writes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write then read back; block must be idle.
    task automatic write_limit(cfp_pkg::reg_idx_t idx, logic [7:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);           // register written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        field_limit[idx] = val;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== val) begin
            $error("readback %s: expected %0d, got %0d", idx.name(), val, prdata[7:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_limits(cfp_pkg::cfg_regs_t v);
        drain();
        for (int i = 0; i < cfp_pkg::NUM_REGS; i++)
            write_limit(cfp_pkg::reg_idx_t'(i), v[i]);
        limit_sets++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == cfp_pkg::COLON_CHAR);
        return b;
    endfunction

    function automatic void add_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    // Well-formed message sized to the current limits, random content.
    task automatic build_message(output byte_q_t q);
        int lim, n, len, lt;
        string txt;
        q = {};
        repeat ($urandom_range(2)) q.push_back(text_byte());   // ignored lead-in
        q.push_back(cfp_pkg::COLON_CHAR);
        for (int f = 0; f < FIELD_COUNT; f++) begin
            if (f == cfp_pkg::PAYLOAD_FIELD) begin
                repeat (len) q.push_back(8'($urandom_range(255)));
                q.push_back(8'($urandom_range(255)));          // terminator slot
            end else if (f == cfp_pkg::LENGTH_FIELD) begin
                lt = field_limit[cfp_pkg::REG_LENGTH_TEXT];
                // overlong digit run first: field and length restart
                if (lt < 20 && $urandom_range(9) == 0)
                    repeat (lt + 2) q.push_back(8'(cfp_pkg::DIGIT_ZERO + $urandom_range(9)));
                if ($urandom_range(24) == 0) len = $urandom_range(256, 999);
                else len = $urandom_range(0, ($urandom_range(3) == 0) ? 60 : 12);
                txt = $sformatf("%0d", len);
                if (txt.len() > lt + 1) begin
                    len = len % 10;
                    txt = $sformatf("%0d", len);
                end
                if (txt.len() < lt + 1 && $urandom_range(3) == 0) txt = {"0", txt};
                if (txt.len() < lt + 1 && $urandom_range(7) == 0) txt = {txt, "x"};
                add_text(q, txt);
                if (len > PAYLOAD_MAX) len = PAYLOAD_MAX;
                q.push_back(cfp_pkg::COLON_CHAR);
            end else begin
                lim = (f < cfp_pkg::PAYLOAD_FIELD) ? field_limit[f]
                    : (f == cfp_pkg::HOPS_FIELD)   ? field_limit[cfp_pkg::REG_HOPS]
                    : field_limit[cfp_pkg::REG_CHECK];
                n = $urandom_range(0, (lim + 3 < 14) ? lim + 3 : 14);
                repeat (n) q.push_back(text_byte());
                q.push_back(cfp_pkg::COLON_CHAR);
            end
        end
    endtask

    // Bring both ports back to idle, then send a message pair, some of it mangled.
    task automatic send_round();
        byte_q_t q[PORTS];
        int kind;
        for (int p = 0; p < PORTS; p++)
            while (port_field_cnt[p] != 0 || port_in_payload[p])
                send_word(cfp_pkg::COLON_CHAR, 1'(p));
        for (int p = 0; p < PORTS; p++) begin
            kind = $urandom_range(11);
            if (kind == 0) begin
                // noise burst, colon-heavy
                q[p] = {};
                repeat ($urandom_range(1, 20))
                    q[p].push_back(($urandom_range(2) == 0) ? cfp_pkg::COLON_CHAR
                                                            : 8'($urandom_range(255)));
            end else if (kind == 1) begin
                q[p] = {};                                     // port stays quiet
            end else begin
                build_message(q[p]);
                if (kind == 2) q[p] = q[p][0:$urandom_range(q[p].size() - 1)];  // cut short
            end
        end
        send_pair(q[0], q[1]);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // One full message on port 0 under reset limits: ignored lead-in, extreme bytes,
    // empty fields, saturating length with a non-digit, overlong length restart,
    // colon and zero inside the payload, terminator, done.
    task automatic test_message_walk();
        byte_q_t q, none;
        q = {};
        none = {};
        add_text(q, "x");
        q.push_back(8'hFF);
        q.push_back(8'h00);
        add_text(q, ":A");
        q.push_back(8'hFF);
        add_text(q, ":::::999x992:");
        q.push_back(cfp_pkg::COLON_CHAR);
        q.push_back(8'h00);
        q.push_back(8'h55);
        add_text(q, "h:");
        q.push_back(8'h80);
        q.push_back(cfp_pkg::COLON_CHAR);
        send_pair(q, none);
        drain();
    endtask

    // Empty length field gives a zero-byte payload on port 1, with port 0 running alongside.
    task automatic test_ports_and_empty_payload();
        byte_q_t q0, q1;
        q1 = {};
        add_text(q1, ":::::::Z::");
        build_message(q0);
        send_pair(q0, q1);
        drain();
    endtask

    // All limits at 0, then all at 255 with a field long enough to wrap the position.
    task automatic test_limit_extremes();
        byte_q_t q, none;
        none = {};
        load_limits('0);
        send_round();
        load_limits({cfp_pkg::NUM_REGS{8'hFF}});
        while (port_field_cnt[0] != 0 || port_in_payload[0])
            send_word(cfp_pkg::COLON_CHAR, 1'b0);
        q = {};
        q.push_back(cfp_pkg::COLON_CHAR);
        repeat (258) q.push_back(text_byte());
        q.push_back(cfp_pkg::COLON_CHAR);
        send_pair(q, none);
        drain();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_len      = 300;
        hold_reqs++;
        send_round();
        drain();
    endtask

    // Random traffic under one stall profile and a fresh limit set.
    task automatic test_random_traffic(int s_idle, int r_stall, int target);
        cfp_pkg::cfg_regs_t v;
        int start;
        bit paused;
        for (int i = 0; i < cfp_pkg::NUM_REGS; i++) begin
            case ($urandom_range(5))
                0:       v[i] = 8'd0;
                1:       v[i] = 8'hFF;
                default: v[i] = 8'($urandom_range(1, 10));
            endcase
        end
        load_limits(v);
        send_idle_pct = s_idle;
        rx_stall_pct  = r_stall;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < target) begin
            send_round();
            if (!paused && bytes_sent - start > target / 2) begin
                drain();                   // sender waits for every result mid-phase
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_message_walk();
        test_ports_and_empty_payload();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic(0,  0,  40);
        test_random_traffic(57, 0,  40);
        test_random_traffic(0,  57, 40);
        test_random_traffic(31, 31, 40);

        drain();
        repeat (10) @(posedge aclk);
        if (predicted_writes.size() != 0) begin
            $error("%0d expected words never arrived", predicted_writes.size());
            errors++;
        end

        $display("Covered %0d bytes over two ports, %0d result words checked, %0d messages done,",
                 bytes_sent, words_checked, messages_seen);
        $display("under %0d limit settings and four stall profiles plus a long receiver hold-off.",
                 limit_sets);
        if (errors == 0) begin
            $display("tb_colon_field_message_parser: PASS");
        end else begin
            $display("tb_colon_field_message_parser: FAIL");
        end
        $finish;
    end

endmodule
